/* hdl/csfd_pkg.sv */
package csfd_pkg;

  localparam int TEMP_CHANNELS = 8;
  localparam int TC_W = $clog2(TEMP_CHANNELS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [28:0] ID_T01_A = 29'h18FF76D3;
  localparam logic [28:0] ID_T01_B = 29'h18FD2083;
  localparam logic [28:0] ID_T23 = 29'h14FD3E83;
  localparam logic [28:0] ID_T4 = 29'h18FDB483;
  localparam logic [28:0] ID_T56 = 29'h18FF75D3;
  localparam logic [28:0] ID_VOLT = 29'h10FD4783;
  localparam logic [28:0] ID_T456 = 29'h18FF74D3;

  localparam logic [2:0] LAY_NONE = 3'd0;
  localparam logic [2:0] LAY_T01 = 3'd1;
  localparam logic [2:0] LAY_T23 = 3'd2;
  localparam logic [2:0] LAY_T4 = 3'd3;
  localparam logic [2:0] LAY_T56 = 3'd4;
  localparam logic [2:0] LAY_T23_ALT = 3'd5;
  localparam logic [2:0] LAY_VOLT = 3'd6;
  localparam logic [2:0] LAY_T456 = 3'd7;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_LO = 3'd1;
  localparam logic [2:0] ERR_HI = 3'd2;
  localparam logic [2:0] ERR_B2 = 3'd3;
  localparam logic [2:0] ERR_B5 = 3'd4;
  localparam logic [2:0] ERR_B7 = 3'd5;

  localparam logic [2:0] REG_START_THR = 3'd0;
  localparam logic [2:0] REG_TOP_THR = 3'd1;
  localparam logic [2:0] REG_COMPANY = 3'd2;
  localparam logic [2:0] REG_PRECISION = 3'd3;
  localparam logic [2:0] REG_TEST_TEMP = 3'd4;
  localparam logic [2:0] REG_REL_TOL = 3'd5;

  localparam logic signed [16:0] TEMP_OFFSET = 17'sd8736;
  localparam logic signed [16:0] VOLT_OFFSET = 17'sd20000;
  localparam logic [16:0] ABS_BAND = 17'd48;

  typedef struct packed {
    logic signed [16:0] start_threshold;
    logic signed [16:0] top_threshold;
    logic company_type;
    logic precision_mode;
    logic [14:0] test_temperature;
    logic relative_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [2:0] layout;
    logic [7:0][7:0] data;
    logic [31:0] tick;
  } job_t;

  typedef struct packed {
    logic [3:0] ch;
    logic [2:0] lo_idx;
    logic [2:0] err_sel;
    logic volt;
  } slot_t;

  function automatic slot_t slot_of(input logic [2:0] layout, input logic [1:0] k);
    slot_t s;
    s = '{ch: 4'd0, lo_idx: 3'd0, err_sel: ERR_NONE, volt: 1'b0};
    unique case (layout)
      LAY_T01: begin
        if (k == 2'd0) s = '{ch: 4'd0, lo_idx: 3'd0, err_sel: ERR_LO, volt: 1'b0};
        else s = '{ch: 4'd1, lo_idx: 3'd2, err_sel: ERR_HI, volt: 1'b0};
      end
      LAY_T23: begin
        if (k == 2'd0) s = '{ch: 4'd2, lo_idx: 3'd0, err_sel: ERR_B2, volt: 1'b0};
        else s = '{ch: 4'd3, lo_idx: 3'd3, err_sel: ERR_B5, volt: 1'b0};
      end
      LAY_T4: begin
        s = '{ch: 4'd4, lo_idx: 3'd2, err_sel: ERR_B5, volt: 1'b0};
      end
      LAY_T56: begin
        if (k == 2'd0) s = '{ch: 4'd5, lo_idx: 3'd0, err_sel: ERR_LO, volt: 1'b0};
        else s = '{ch: 4'd6, lo_idx: 3'd2, err_sel: ERR_HI, volt: 1'b0};
      end
      LAY_T23_ALT: begin
        if (k == 2'd0) s = '{ch: 4'd2, lo_idx: 3'd0, err_sel: ERR_LO, volt: 1'b0};
        else s = '{ch: 4'd3, lo_idx: 3'd2, err_sel: ERR_HI, volt: 1'b0};
      end
      LAY_VOLT: begin
        s = '{ch: 4'd7 + {2'b00, k}, lo_idx: {k, 1'b0}, err_sel: ERR_NONE, volt: 1'b1};
      end
      LAY_T456: begin
        if (k == 2'd0) s = '{ch: 4'd4, lo_idx: 3'd0, err_sel: ERR_LO, volt: 1'b0};
        else if (k == 2'd1) s = '{ch: 4'd5, lo_idx: 3'd2, err_sel: ERR_HI, volt: 1'b0};
        else s = '{ch: 4'd6, lo_idx: 3'd4, err_sel: ERR_B7, volt: 1'b0};
      end
      default: begin
        s = '{ch: 4'd0, lo_idx: 3'd0, err_sel: ERR_NONE, volt: 1'b0};
      end
    endcase
    return s;
  endfunction

  function automatic logic [1:0] slot_last(input logic [2:0] layout);
    logic [1:0] n;
    unique case (layout) inside
      LAY_T01, LAY_T23, LAY_T56, LAY_T23_ALT: n = 2'd1;
      LAY_T456: n = 2'd2;
      LAY_VOLT: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* hdl/csfd_front.sv */
module csfd_front import csfd_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [28:0] frame_id,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  input  logic [31:0] tick_ms,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [2:0] layout;

  always_comb begin
    unique case (frame_id) inside
      ID_T01_A, ID_T01_B: layout = LAY_T01;
      ID_T23: layout = LAY_T23;
      ID_T4: layout = LAY_T4;
      ID_T56: layout = cfg.company_type ? LAY_T23_ALT : LAY_T56;
      ID_VOLT: layout = LAY_VOLT;
      ID_T456: layout = LAY_T456;
      default: layout = LAY_NONE;
    endcase
  end

  // drop frames that carry no channel
  assign in_stall = q_full;
  assign q_push = in_valid && !q_full && (layout != LAY_NONE);
  assign q_job.layout = layout;
  assign q_job.data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
  assign q_job.tick = tick_ms;

endmodule

/* hdl/csfd_fifo.sv */
module csfd_fifo import csfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;

  function automatic logic [QA_W-1:0] bump(input logic [QA_W-1:0] p);
    return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + QA_W'(1);
  endfunction

  assign full = (count == QC_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + QC_W'(1);
      else if (pop && !push) count <= count - QC_W'(1);
    end
  end

endmodule

/* hdl/csfd_back.sv */
module csfd_back import csfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         channel,
  output logic signed [16:0] value,
  output logic               is_voltage,
  output logic [4:0]         error_code,
  output logic [31:0]        elapsed_ms,
  output logic               in_tolerance,
  output logic               last
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  slot_t slot;
  logic issue_last;
  logic advance;

  logic a_valid;
  logic [3:0] a_ch;
  logic signed [16:0] a_value;
  logic a_volt;
  logic [4:0] a_err;
  logic [31:0] a_tick;
  logic a_last;

  logic [15:0] raw;
  logic signed [16:0] raw_value;
  logic [4:0] raw_err;

  logic start_armed [TEMP_CHANNELS];
  logic top_armed [TEMP_CHANNELS];
  logic [31:0] start_time [TEMP_CHANNELS];
  logic [31:0] top_time [TEMP_CHANNELS];

  logic [TC_W-1:0] si;
  logic is_temp;
  logic start_armed_next;
  logic top_armed_next;
  logic [31:0] start_time_next;
  logic [31:0] top_time_next;
  logic [31:0] elapsed;
  logic signed [17:0] diff;
  logic [16:0] mag;
  logic [24:0] scaled;
  logic tol;

  assign advance = !out_valid || !out_stall;
  assign last_idx = slot_last(q_job.layout);
  assign slot = slot_of(q_job.layout, idx);
  assign issue_last = (idx == last_idx);
  assign q_pop = advance && q_valid && issue_last;

  always_comb begin
    raw = {q_job.data[slot.lo_idx + 3'd1], q_job.data[slot.lo_idx]};
    raw_value = $signed({1'b0, raw}) - (slot.volt ? VOLT_OFFSET : TEMP_OFFSET);
    unique case (slot.err_sel)
      ERR_LO: raw_err = q_job.data[6][4:0];
      ERR_HI: raw_err = {q_job.data[7][1:0], q_job.data[6][7:5]};
      ERR_B2: raw_err = q_job.data[2][4:0];
      ERR_B5: raw_err = {1'b0, q_job.data[5][4:1]};
      ERR_B7: raw_err = q_job.data[7][6:2];
      default: raw_err = 5'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= q_valid;
      if (q_valid) idx <= issue_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_valid) begin
      a_ch <= slot.ch;
      a_value <= raw_value;
      a_volt <= slot.volt;
      a_err <= raw_err;
      a_tick <= q_job.tick;
      a_last <= issue_last;
    end
  end

  always_comb begin
    si = a_ch[TC_W-1:0];
    is_temp = !a_volt && (32'(a_ch) < TEMP_CHANNELS);

    start_armed_next = start_armed[si];
    start_time_next = start_time[si];
    if (a_value < cfg.start_threshold) start_armed_next = 1'b0;
    if (!start_armed_next && (a_value > cfg.start_threshold)) begin
      start_armed_next = 1'b1;
      start_time_next = a_tick;
    end

    top_armed_next = top_armed[si];
    top_time_next = top_time[si];
    if (a_value < cfg.top_threshold) top_armed_next = 1'b0;
    if (!top_armed_next && (a_value > cfg.top_threshold)) begin
      top_armed_next = 1'b1;
      top_time_next = a_tick;
    end

    elapsed = (is_temp && (top_time_next > start_time_next)) ?
              top_time_next - start_time_next : 32'd0;

    diff = $signed({a_value[16], a_value}) - $signed({3'b000, cfg.test_temperature});
    mag = diff[17] ? 17'(-diff) : diff[16:0];
    scaled = (25'(mag) << 8) - (25'(mag) << 2) - (25'(mag) << 1);
    if (!cfg.precision_mode || a_volt) tol = 1'b0;
    else if (cfg.relative_tolerance) tol = scaled < 25'(cfg.test_temperature);
    else tol = mag < ABS_BAND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < TEMP_CHANNELS; i++) begin
        start_armed[i] <= 1'b0;
        top_armed[i] <= 1'b0;
        start_time[i] <= 32'd0;
        top_time[i] <= 32'd0;
      end
    end else if (advance) begin
      out_valid <= a_valid;
      if (a_valid && is_temp) begin
        start_armed[si] <= start_armed_next;
        top_armed[si] <= top_armed_next;
        start_time[si] <= start_time_next;
        top_time[si] <= top_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      channel <= a_ch;
      value <= a_value;
      is_voltage <= a_volt;
      error_code <= a_volt ? 5'd0 : a_err;
      elapsed_ms <= elapsed;
      in_tolerance <= tol;
      last <= a_last;
    end
  end

  default disable iff (rst);

  assert property (@(posedge clk) q_valid |-> idx <= last_idx)
    else $error("issue index past the last slot of the head frame");

  assert property (@(posedge clk)
      out_valid && is_voltage |-> error_code == 5'd0 && elapsed_ms == 32'd0 && !in_tolerance)
    else $error("voltage beat carries temperature status");

  assert property (@(posedge clk) q_pop |-> q_valid && issue_last)
    else $error("queue popped before the frame's last slot");

  assert property (@(posedge clk) out_valid && out_stall |=> $stable(channel) && $stable(last))
    else $error("stalled result changed");

endmodule

/* hdl/can_sensor_frame_decoder.sv */
// A frame with channels enters the frame queue; each of its results then passes through
// the issue and output registers. Throughput: one result beat per cycle while out_stall
// is low; a frame gives 1 to 4 beats (one per channel). A 2-entry frame queue lets the
// input accept while results drain; channel-less frames are accepted and produce nothing.
// Reset (rst, synchronous): clears queue, pipeline, configuration and channel timing state.
module can_sensor_frame_decoder import csfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [28:0]        frame_id,
  input  logic [7:0]         byte0,
  input  logic [7:0]         byte1,
  input  logic [7:0]         byte2,
  input  logic [7:0]         byte3,
  input  logic [7:0]         byte4,
  input  logic [7:0]         byte5,
  input  logic [7:0]         byte6,
  input  logic [7:0]         byte7,
  input  logic [31:0]        tick_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         channel,
  output logic signed [16:0] value,
  output logic               is_voltage,
  output logic [4:0]         error_code,
  output logic [31:0]        elapsed_ms,
  output logic               in_tolerance,
  output logic               last
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t push_job;
  logic q_pop;
  logic q_valid;
  job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_THR: cfg.start_threshold <= $signed(cfg_data);
        REG_TOP_THR: cfg.top_threshold <= $signed(cfg_data);
        REG_COMPANY: cfg.company_type <= cfg_data[0];
        REG_PRECISION: cfg.precision_mode <= cfg_data[0];
        REG_TEST_TEMP: cfg.test_temperature <= cfg_data[14:0];
        REG_REL_TOL: cfg.relative_tolerance <= cfg_data[0];
        default: ;
      endcase
    end
  end

  csfd_front u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_id(frame_id),
    .byte0(byte0),
    .byte1(byte1),
    .byte2(byte2),
    .byte3(byte3),
    .byte4(byte4),
    .byte5(byte5),
    .byte6(byte6),
    .byte7(byte7),
    .tick_ms(tick_ms),
    .cfg(cfg),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(push_job)
  );

  csfd_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_valid),
    .head_job(head_job)
  );

  csfd_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_job(head_job),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .channel(channel),
    .value(value),
    .is_voltage(is_voltage),
    .error_code(error_code),
    .elapsed_ms(elapsed_ms),
    .in_tolerance(in_tolerance),
    .last(last)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench import csfd_pkg::*; ();

  localparam logic [28:0] ID_UNUSED = 29'h18FF77D3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct {
    logic [28:0] id;
    logic [7:0][7:0] b;
    logic [31:0] tick;
    bit wait_drain;
  } frame_t;

  typedef struct {
    logic [3:0] channel;
    logic signed [16:0] value;
    logic is_voltage;
    logic [4:0] error_code;
    logic [31:0] elapsed_ms;
    logic in_tolerance;
    logic last;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [28:0] frame_id = '0;
  logic [7:0] byte0 = '0;
  logic [7:0] byte1 = '0;
  logic [7:0] byte2 = '0;
  logic [7:0] byte3 = '0;
  logic [7:0] byte4 = '0;
  logic [7:0] byte5 = '0;
  logic [7:0] byte6 = '0;
  logic [7:0] byte7 = '0;
  logic [31:0] tick_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] channel;
  logic signed [16:0] value;
  logic is_voltage;
  logic [4:0] error_code;
  logic [31:0] elapsed_ms;
  logic in_tolerance;
  logic last;

  can_sensor_frame_decoder dut (.*);

  initial forever #5 clk = ~clk;

  // decoder configuration as the block should hold it
  logic signed [16:0] thr_start = '0;
  logic signed [16:0] thr_top = '0;
  bit company_sel = 1'b0;
  bit precision_on = 1'b0;
  logic [14:0] test_temp = '0;
  bit rel_tol = 1'b0;

  // rise-time tracking per temperature channel
  bit start_armed [TEMP_CHANNELS];
  bit top_armed [TEMP_CHANNELS];
  logic [31:0] start_time [TEMP_CHANNELS];
  logic [31:0] top_time [TEMP_CHANNELS];

  frame_t pending_frames [$];
  reading_t expected_readings [$];
  frame_t cur_frame;
  reading_t head;
  int mismatches = 0;
  int cycle_count = 0;
  logic [31:0] tick_now = '0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  function automatic reading_t temp_reading(input logic [3:0] ch, input logic [7:0] lo,
                                            input logic [7:0] hi, input logic [4:0] err,
                                            input logic [31:0] tick);
    reading_t r;
    int v;
    longint d;
    v = int'({hi, lo}) - int'(TEMP_OFFSET);
    if (v < int'(thr_start)) start_armed[ch] = 1'b0;
    if (!start_armed[ch] && v > int'(thr_start)) begin
      start_time[ch] = tick;
      start_armed[ch] = 1'b1;
    end
    if (v < int'(thr_top)) top_armed[ch] = 1'b0;
    if (!top_armed[ch] && v > int'(thr_top)) begin
      top_time[ch] = tick;
      top_armed[ch] = 1'b1;
    end
    r.elapsed_ms = (top_time[ch] > start_time[ch]) ? top_time[ch] - start_time[ch] : '0;
    r.in_tolerance = 1'b0;
    if (precision_on) begin
      d = longint'(v) - longint'(test_temp);
      if (d < 0) d = -d;
      if (rel_tol) r.in_tolerance = (d * 250 < longint'(test_temp));
      else r.in_tolerance = (d < longint'(ABS_BAND));
    end
    r.channel = ch;
    r.value = v[16:0];
    r.is_voltage = 1'b0;
    r.error_code = err;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic reading_t volt_reading(input logic [3:0] ch, input logic [7:0] lo,
                                            input logic [7:0] hi);
    reading_t r;
    int v;
    v = int'({hi, lo}) - int'(VOLT_OFFSET);
    r.channel = ch;
    r.value = v[16:0];
    r.is_voltage = 1'b1;
    r.error_code = '0;
    r.elapsed_ms = '0;
    r.in_tolerance = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic decode_frame(input frame_t f);
    reading_t rd [$];
    logic [4:0] e_lo;
    logic [4:0] e_hi;
    e_lo = f.b[6][4:0];
    e_hi = {f.b[7][1:0], f.b[6][7:5]};
    case (f.id) inside
      ID_T01_A, ID_T01_B: begin
        rd = {rd, temp_reading(4'd0, f.b[0], f.b[1], e_lo, f.tick)};
        rd = {rd, temp_reading(4'd1, f.b[2], f.b[3], e_hi, f.tick)};
      end
      ID_T23: begin
        rd = {rd, temp_reading(4'd2, f.b[0], f.b[1], f.b[2][4:0], f.tick)};
        rd = {rd, temp_reading(4'd3, f.b[3], f.b[4], {1'b0, f.b[5][4:1]}, f.tick)};
      end
      ID_T4: begin
        rd = {rd, temp_reading(4'd4, f.b[2], f.b[3], {1'b0, f.b[5][4:1]}, f.tick)};
      end
      ID_T56: begin
        if (!company_sel) begin
          rd = {rd, temp_reading(4'd5, f.b[0], f.b[1], e_lo, f.tick)};
          rd = {rd, temp_reading(4'd6, f.b[2], f.b[3], e_hi, f.tick)};
        end else begin
          rd = {rd, temp_reading(4'd2, f.b[0], f.b[1], e_lo, f.tick)};
          rd = {rd, temp_reading(4'd3, f.b[2], f.b[3], e_hi, f.tick)};
        end
      end
      ID_VOLT: begin
        rd = {rd, volt_reading(4'd7, f.b[0], f.b[1])};
        rd = {rd, volt_reading(4'd8, f.b[2], f.b[3])};
        rd = {rd, volt_reading(4'd9, f.b[4], f.b[5])};
        rd = {rd, volt_reading(4'd10, f.b[6], f.b[7])};
      end
      ID_T456: begin
        rd = {rd, temp_reading(4'd4, f.b[0], f.b[1], e_lo, f.tick)};
        rd = {rd, temp_reading(4'd5, f.b[2], f.b[3], e_hi, f.tick)};
        rd = {rd, temp_reading(4'd6, f.b[4], f.b[5], f.b[7][6:2], f.tick)};
      end
      default: begin
      end
    endcase
    if (rd.size() > 0) rd[rd.size() - 1].last = 1'b1;
    expected_readings = {expected_readings, rd};
  endtask

  function automatic logic [15:0] pick_raw();
    int r;
    case ($urandom_range(3))
      0: r = int'($urandom_range(65535));
      1: r = int'(thr_start) + int'(TEMP_OFFSET) + int'($urandom_range(8)) - 4;
      2: r = int'(thr_top) + int'(TEMP_OFFSET) + int'($urandom_range(8)) - 4;
      default: r = int'(test_temp) + int'(TEMP_OFFSET) + int'($urandom_range(300)) - 150;
    endcase
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  function automatic frame_t make_frame();
    frame_t f;
    int sel;
    logic [28:0] ids [7];
    ids = '{ID_T01_A, ID_T01_B, ID_T23, ID_T4, ID_T56, ID_VOLT, ID_T456};
    f.b = {$urandom, $urandom};
    f.wait_drain = 1'b0;
    sel = $urandom_range(99);
    if (sel < 90) f.id = ids[$urandom_range(6)];
    else if (sel < 94) f.id = ID_UNUSED;
    else if (sel < 97) f.id = 29'($urandom);
    else f.id = ids[$urandom_range(6)] ^ (29'd1 << $urandom_range(28));
    if ($urandom_range(99) < 80) begin
      case (f.id) inside
        ID_T01_A, ID_T01_B, ID_T56: begin
          {f.b[1], f.b[0]} = pick_raw();
          {f.b[3], f.b[2]} = pick_raw();
        end
        ID_T23: begin
          {f.b[1], f.b[0]} = pick_raw();
          {f.b[4], f.b[3]} = pick_raw();
        end
        ID_T4: {f.b[3], f.b[2]} = pick_raw();
        ID_T456: begin
          {f.b[1], f.b[0]} = pick_raw();
          {f.b[3], f.b[2]} = pick_raw();
          {f.b[5], f.b[4]} = pick_raw();
        end
        default: begin
        end
      endcase
    end
    tick_now = tick_now + $urandom_range(2000);
    f.tick = ($urandom_range(99) < 10) ? $urandom : tick_now;
    return f;
  endfunction

  task automatic queue_frame(input logic [28:0] id, input logic [63:0] data,
                             input logic [31:0] tick);
    frame_t f;
    f.id = id;
    f.b = data;
    f.tick = tick;
    f.wait_drain = 1'b0;
    pending_frames = {pending_frames, f};
  endtask

  task automatic queue_random(input int count, input int drain_every);
    frame_t f;
    for (int i = 0; i < count; i++) begin
      f = make_frame();
      f.wait_drain = (drain_every > 0) && (i % drain_every == drain_every - 1);
      pending_frames = {pending_frames, f};
    end
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_THR: thr_start = data;
      REG_TOP_THR: thr_top = data;
      REG_COMPANY: company_sel = data[0];
      REG_PRECISION: precision_on = data[0];
      REG_TEST_TEMP: test_temp = data[14:0];
      REG_REL_TOL: rel_tol = data[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input int start_thr, input int top_thr, input bit company,
                            input bit precision, input int test_t, input bit rel);
    write_reg(REG_START_THR, start_thr[16:0]);
    write_reg(REG_TOP_THR, top_thr[16:0]);
    write_reg(REG_COMPANY, {16'd0, company});
    write_reg(REG_PRECISION, {16'd0, precision});
    write_reg(REG_TEST_TEMP, test_t[16:0]);
    write_reg(REG_REL_TOL, {16'd0, rel});
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_config();
    int s;
    s = int'($urandom_range(20000)) - 2000;
    set_config(s, s + int'($urandom_range(4000)), 1'($urandom_range(1)),
               1'($urandom_range(1)), int'($urandom_range(25600)), 1'($urandom_range(1)));
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_frame(cur_frame);
      if (!in_valid || !in_stall) begin
        if (pending_frames.size() > 0 &&
            !(pending_frames[0].wait_drain && expected_readings.size() > 0) &&
            !(gaps_on && $urandom_range(99) < 10)) begin
          cur_frame = pending_frames.pop_front();
          frame_id <= cur_frame.id;
          byte0 <= cur_frame.b[0];
          byte1 <= cur_frame.b[1];
          byte2 <= cur_frame.b[2];
          byte3 <= cur_frame.b[3];
          byte4 <= cur_frame.b[4];
          byte5 <= cur_frame.b[5];
          byte6 <= cur_frame.b[6];
          byte7 <= cur_frame.b[7];
          tick_ms <= cur_frame.tick;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual channel %0d value %0d",
                   $time, channel, value);
          mismatches++;
        end else begin
          head = expected_readings.pop_front();
          check_field("channel", head.channel, channel);
          check_field("value", head.value, value);
          check_field("is_voltage", head.is_voltage, is_voltage);
          check_field("error_code", head.error_code, error_code);
          check_field("elapsed_ms", head.elapsed_ms, elapsed_ms);
          check_field("in_tolerance", head.in_tolerance, in_tolerance);
          check_field("last", head.last, last);
        end
      end
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_readings.size());
      $display("can_sensor_frame_decoder test failed");
      $finish;
    end
  end

  initial begin
    foreach (start_armed[i]) begin
      start_armed[i] = 1'b0;
      top_armed[i] = 1'b0;
      start_time[i] = '0;
      top_time[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every frame ID and some unused IDs, mostly at the byte extremes, under the reset configuration
    queue_frame(ID_T01_A, 64'h0, 32'h0);
    queue_frame(ID_T01_A, {64{1'b1}}, 32'hFFFF_FFFF);
    queue_frame(ID_T01_B, {$urandom, $urandom}, 32'd100);
    queue_frame(ID_T23, {64{1'b1}}, 32'd200);
    queue_frame(ID_T4, 64'h0, 32'd300);
    queue_frame(ID_T56, {64{1'b1}}, 32'd400);
    queue_frame(ID_VOLT, 64'h0, 32'd500);
    queue_frame(ID_VOLT, {64{1'b1}}, 32'd600);
    queue_frame(ID_T456, {64{1'b1}}, 32'd700);
    queue_frame(ID_T456, {$urandom, $urandom}, 32'd800);
    queue_frame(ID_UNUSED, {64{1'b1}}, 32'd900);
    queue_frame(29'h0, {$urandom, $urandom}, 32'd1000);
    queue_frame({29{1'b1}}, {$urandom, $urandom}, 32'd1100);
    drain();

    // alternate company layout, relative band edges
    set_config(3000, 6000, 1'b1, 1'b1, 25600, 1'b1);
    queue_frame(ID_T56, 64'h0000_0000_8686_8620, 32'd2000);
    queue_frame(ID_T56, 64'hFFFF_0000_85B9_8687, 32'd2500);
    queue_frame(ID_T01_B, 64'hA5C3_0000_8620_8686, 32'd1500);
    drain();

    // absolute band edges, threshold extremes
    set_config(-8736, 56799, 1'b0, 1'b1, 0, 1'b0);
    queue_frame(ID_T01_A, 64'h5A3C_0000_21F1_224F, 32'd3000);
    queue_frame(ID_T01_A, 64'h0000_0000_2250_2250, 32'd3100);
    drain();

    set_config(-8736, 56799, 1'b0, 1'b0, 0, 1'b0);
    queue_random(40, 0);
    drain();

    gaps_on = 1'b0;
    set_config(320, 3200, 1'b1, 1'b1, 25600, 1'b0);
    queue_random(60, 0);
    drain();
    gaps_on = 1'b1;

    set_config(56799, -8736, 1'b0, 1'b1, 0, 1'b1);
    queue_random(40, 0);
    drain();

    // long receiver hold-off while frames keep coming
    set_random_config();
    hold_req = 1'b1;
    queue_random(60, 0);
    drain();

    set_random_config();
    queue_random(60, 12);
    drain();

    set_random_config();
    queue_random(40, 0);
    drain();

    if (mismatches == 0) begin
      $display("can_sensor_frame_decoder test passed");
    end else begin
      $display("can_sensor_frame_decoder test failed");
    end
    $finish;
  end

endmodule
